// ===== rtl/ssbh_pkg.sv =====
// ----------------------------------------------------------------------------
// ssbh_pkg
// Shared types, constants and helpers for the swept sphere / box hit block.
// ----------------------------------------------------------------------------
package ssbh_pkg;

  // lane layout of packed vectors
  localparam int LANE_W   = 16;
  localparam int TFRAC    = 14;
  localparam int T_W      = 16;
  localparam int MARGIN_W = 14;
  localparam int NUM_FACES = 6;

  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 14'd164;
  localparam logic [T_W-1:0]      T_SAT        = 16'hFFFF;

  // input word layout
  localparam int IN_W       = 320;
  localparam int OFS_POS    = 0;
  localparam int OFS_MOTION = 48;
  localparam int OFS_RADIUS = 96;
  localparam int OFS_AXIS_X = 111;
  localparam int OFS_SIZE   = 255;
  localparam int OFS_TLIM   = 303;
  localparam int RADIUS_W   = 15;

  // output word layout
  localparam int OUT_W = 72;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  // face order -x, +x, -z, +z, +y, -y
  localparam axis_t FACE_AXIS [NUM_FACES] = '{AXIS_X, AXIS_X, AXIS_Z, AXIS_Z, AXIS_Y, AXIS_Y};
  localparam logic [NUM_FACES-1:0] FACE_POS = 6'b011010;

  // saturating negation of one Q1.14 lane
  function automatic logic [LANE_W-1:0] neg_sat16(input logic [LANE_W-1:0] v);
    logic signed [LANE_W-1:0] sv;
    sv = $signed(v);
    if (v == 16'h8000) return 16'h7FFF;
    return LANE_W'(-sv);
  endfunction

endpackage

// ===== rtl/ssbh_front.sv =====
// ----------------------------------------------------------------------------
// ssbh_front
// Front stages: projection onto the box axes, inside test, extents and the
// per-face numerator / denominator with skip flags.
// ----------------------------------------------------------------------------
module ssbh_front import ssbh_pkg::*; #(
  parameter int CW = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [IN_W-1:0]              word,
  output logic                         f_valid,
  output logic [NUM_FACES-1:0][CW:0]   f_num,
  output logic [NUM_FACES-1:0][CW:0]   f_den,
  output logic [NUM_FACES-1:0]         f_skip,
  output logic [2:0][CW-1:0]           f_c,
  output logic [2:0][CW-1:0]           f_d,
  output logic [2:0][CW-1:0]           f_e,
  output logic [2:0][2:0][LANE_W-1:0]  f_axis,
  output logic [T_W-1:0]               f_tlim,
  output logic                         f_inside
);

  localparam logic signed [63:0] C_HI = (64'sd1 <<< (CW - 1)) - 64'sd1;
  localparam logic signed [63:0] C_LO = -C_HI - 64'sd1;
  localparam int XW  = CW + 18;
  localparam int NXW = CW + 3;

  function automatic logic [CW-1:0] sat_cw(input logic signed [63:0] x);
    logic signed [63:0] y;
    y = (x > C_HI) ? C_HI : ((x < C_LO) ? C_LO : x);
    return y[CW-1:0];
  endfunction

  logic [5:1] v;

  // stage 1: input capture
  logic [2:0][LANE_W-1:0]       rp1, mv1, sz1;
  logic [2:0][2:0][LANE_W-1:0]  ax1;
  logic [RADIUS_W-1:0]          rad1;
  logic [T_W-1:0]               tl1;
  // stage 2: products
  logic signed [31:0]           pp2 [3][3];
  logic signed [31:0]           pm2 [3][3];
  logic [2:0][LANE_W-1:0]       sz2;
  logic [2:0][2:0][LANE_W-1:0]  ax2;
  logic [RADIUS_W-1:0]          rad2;
  logic [T_W-1:0]               tl2;
  // stage 3: projected coordinates
  logic [2:0][CW-1:0]           c3, d3;
  logic [2:0][LANE_W-1:0]       sz3;
  logic [2:0][2:0][LANE_W-1:0]  ax3;
  logic [RADIUS_W-1:0]          rad3;
  logic [T_W-1:0]               tl3;
  // stage 4: inside and extents
  logic [2:0][CW-1:0]           c4, d4, e4;
  logic [2:0][2:0][LANE_W-1:0]  ax4;
  logic [T_W-1:0]               tl4;
  logic                         in4;

  logic [2:0][CW-1:0]           c3_next, d3_next, e4_next;
  logic                         in4_next;
  logic [NUM_FACES-1:0][CW:0]   num_next, den_next;
  logic [NUM_FACES-1:0]         skip_next;

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[4:1], accept};
    end
  end

  // projection sums, floor shift and saturation
  always_comb begin
    logic signed [33:0] sp, sm;
    for (int a = 0; a < 3; a++) begin
      sp = 34'(pp2[a][0]) + 34'(pp2[a][1]) + 34'(pp2[a][2]);
      sm = 34'(pm2[a][0]) + 34'(pm2[a][1]) + 34'(pm2[a][2]);
      c3_next[a] = sat_cw(64'(sp >>> TFRAC));
      d3_next[a] = sat_cw(64'(sm >>> TFRAC));
    end
  end

  // inside test and widened or narrowed extents
  always_comb begin
    logic signed [XW-1:0] tcx, szx, r2x;
    in4_next = 1'b1;
    for (int a = 0; a < 3; a++) begin
      tcx = XW'($signed(c3[a])) <<< 1;
      szx = $signed({{(XW-LANE_W){1'b0}}, sz3[a]});
      if (tcx > szx || tcx < -szx) in4_next = 1'b0;
    end
    for (int a = 0; a < 3; a++) begin
      szx = $signed({{(XW-LANE_W){1'b0}}, sz3[a]});
      r2x = $signed({{(XW-RADIUS_W-1){1'b0}}, rad3, 1'b0});
      e4_next[a] = in4_next ? sat_cw(64'(szx - r2x)) : sat_cw(64'(szx + r2x));
    end
  end

  // per-face numerator and denominator, sign normalized
  always_comb begin
    logic signed [NXW-1:0] tc, td, ex, nm, dn;
    for (int f = 0; f < NUM_FACES; f++) begin
      tc = NXW'($signed(c4[FACE_AXIS[f]])) <<< 1;
      td = NXW'($signed(d4[FACE_AXIS[f]])) <<< 1;
      ex = NXW'($signed(e4[FACE_AXIS[f]]));
      nm = FACE_POS[f] ? ex - tc : ex + tc;
      dn = FACE_POS[f] ? td : -td;
      if (dn < 0) begin
        nm = -nm;
        dn = -dn;
      end
      skip_next[f] = (dn == '0) || (nm < 0);
      num_next[f]  = nm[CW:0];
      den_next[f]  = dn[CW:0];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      rp1  <= word[OFS_POS +: 48];
      mv1  <= word[OFS_MOTION +: 48];
      rad1 <= word[OFS_RADIUS +: RADIUS_W];
      ax1  <= word[OFS_AXIS_X +: 144];
      sz1  <= word[OFS_SIZE +: 48];
      tl1  <= word[OFS_TLIM +: T_W];
    end
    for (int a = 0; a < 3; a++) begin
      for (int k = 0; k < 3; k++) begin
        pp2[a][k] <= $signed(rp1[k]) * $signed(ax1[a][k]);
        pm2[a][k] <= $signed(mv1[k]) * $signed(ax1[a][k]);
      end
    end
    sz2  <= sz1;
    ax2  <= ax1;
    rad2 <= rad1;
    tl2  <= tl1;
    c3   <= c3_next;
    d3   <= d3_next;
    sz3  <= sz2;
    ax3  <= ax2;
    rad3 <= rad2;
    tl3  <= tl2;
    c4   <= c3;
    d4   <= d3;
    e4   <= e4_next;
    in4  <= in4_next;
    ax4  <= ax3;
    tl4  <= tl3;
    f_num    <= num_next;
    f_den    <= den_next;
    f_skip   <= skip_next;
    f_c      <= c4;
    f_d      <= d4;
    f_e      <= e4;
    f_axis   <= ax4;
    f_tlim   <= tl4;
    f_inside <= in4;
  end

  assign f_valid = v[5];

endmodule

// ===== rtl/ssbh_queue.sv =====
// ----------------------------------------------------------------------------
// ssbh_queue
// Small first-in first-out buffer between the front and back stages.
// ----------------------------------------------------------------------------
module ssbh_queue import ssbh_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic         q_valid,
  output logic [W-1:0] rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [W-1:0]     mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wdata;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  assign q_valid = (count != '0);
  assign rdata   = mem[rd_ptr];

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> count < CNT_W'(DEPTH))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("queue read while empty");

endmodule

// ===== rtl/ssbh_back.sv =====
// ----------------------------------------------------------------------------
// ssbh_back
// Back stages: per-face time division, containment test, ordered face
// resolution against the running limit and the output register.
// ----------------------------------------------------------------------------
module ssbh_back import ssbh_pkg::*; #(
  parameter int CW = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [MARGIN_W-1:0]          time_margin,
  input  logic                         q_valid,
  output logic                         q_pop,
  input  logic [NUM_FACES-1:0][CW:0]   q_num,
  input  logic [NUM_FACES-1:0][CW:0]   q_den,
  input  logic [NUM_FACES-1:0]         q_skip,
  input  logic [2:0][CW-1:0]           q_c,
  input  logic [2:0][CW-1:0]           q_d,
  input  logic [2:0][CW-1:0]           q_e,
  input  logic [2:0][2:0][LANE_W-1:0]  q_axis,
  input  logic [T_W-1:0]               q_tlim,
  input  logic                         q_inside,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic                         hit_o,
  output logic [47:0]                  normal_o,
  output logic [T_W-1:0]               t_out_o
);

  localparam int RW      = CW + 3;
  localparam int PW      = 2 * CW + 4;
  localparam int DIV_END = T_W;
  localparam int RES_END = DIV_END + NUM_FACES;
  localparam int LAST    = RES_END + 1;

  logic [LAST:0] v;
  logic          en;

  logic [2:0][CW-1:0]             c0, d0, e0;
  logic [NUM_FACES-1:0][RW-1:0]   r_s   [DIV_END+1];
  logic [NUM_FACES-1:0][RW-1:0]   r_n   [DIV_END+1];
  logic [NUM_FACES-1:0][CW:0]     den_s [DIV_END+1];
  logic [NUM_FACES-1:0][T_W-1:0]  q_s   [RES_END+1];
  logic [NUM_FACES-1:0][T_W-1:0]  q_n   [DIV_END+1];
  logic [NUM_FACES-1:0]           sat_s [RES_END+1];
  logic [NUM_FACES-1:0]           skip_s[RES_END+1];
  logic [NUM_FACES-1:0]           ok_s  [RES_END+1];
  logic [NUM_FACES-1:0]           ok_n;
  logic signed [PW-1:0]           pa1 [NUM_FACES][3];
  logic signed [PW-1:0]           pb1 [NUM_FACES][3];
  logic signed [PW-1:0]           pe1 [NUM_FACES][3];
  logic [2:0][2:0][LANE_W-1:0]    ax_s  [RES_END+1];
  logic                           in_s  [RES_END+1];
  logic [T_W-1:0]                 lim_s [RES_END+1];
  logic [T_W-1:0]                 lim_n [RES_END+1];
  logic                           hit_s [RES_END+1];
  logic                           hit_n [RES_END+1];
  axis_t                          nax_s [RES_END+1];
  axis_t                          nax_n [RES_END+1];
  logic                           pos_s [RES_END+1];
  logic                           pos_n [RES_END+1];
  logic [47:0]                    normal_next;

  // whole back pipe moves unless the output word is held
  assign en        = !v[LAST] || out_ready;
  assign q_pop     = en && q_valid;
  assign out_valid = v[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[LAST-1:0], q_valid};
    end
  end

  // one quotient bit per stage, integer bits first
  always_comb begin
    logic [RW-1:0] cur, sub;
    int b;
    for (int s = 0; s <= DIV_END; s++) begin
      r_n[s] = r_s[s];
      q_n[s] = q_s[s];
    end
    for (int s = 1; s <= DIV_END; s++) begin
      b = DIV_END - s;
      for (int f = 0; f < NUM_FACES; f++) begin
        if (b >= TFRAC) begin
          cur = r_s[s-1][f];
          sub = RW'(den_s[s-1][f]) << (b - TFRAC);
        end else begin
          cur = r_s[s-1][f] << 1;
          sub = RW'(den_s[s-1][f]);
        end
        r_n[s][f] = (cur >= sub) ? cur - sub : cur;
        q_n[s][f] = q_s[s-1][f] | (T_W'(cur >= sub) << b);
      end
    end
  end

  // containment check: crossing point within extents on every axis
  always_comb begin
    logic signed [PW-1:0] p;
    for (int f = 0; f < NUM_FACES; f++) begin
      ok_n[f] = 1'b1;
      for (int k = 0; k < 3; k++) begin
        p = pa1[f][k] + pb1[f][k];
        if (p > pe1[f][k] || p < -pe1[f][k]) ok_n[f] = 1'b0;
      end
    end
  end

  // ordered face resolution against the running limit
  always_comb begin
    logic [T_W-1:0] tq;
    logic           acc;
    int             f;
    lim_n[0] = lim_s[0];
    hit_n[0] = hit_s[0];
    nax_n[0] = nax_s[0];
    pos_n[0] = pos_s[0];
    // limit and face choice ride along while the quotient forms
    for (int s = 1; s <= DIV_END; s++) begin
      lim_n[s] = lim_s[s-1];
      hit_n[s] = hit_s[s-1];
      nax_n[s] = nax_s[s-1];
      pos_n[s] = pos_s[s-1];
    end
    for (int s = DIV_END + 1; s <= RES_END; s++) begin
      f   = s - DIV_END - 1;
      tq  = sat_s[s-1][f] ? T_SAT : q_s[s-1][f];
      acc = !skip_s[s-1][f] && ok_s[s-1][f] && (tq < lim_s[s-1]);
      lim_n[s] = lim_s[s-1];
      hit_n[s] = hit_s[s-1];
      nax_n[s] = nax_s[s-1];
      pos_n[s] = pos_s[s-1];
      if (acc) begin
        lim_n[s] = (tq > T_W'(time_margin)) ? tq - T_W'(time_margin) : '0;
        hit_n[s] = 1'b1;
        nax_n[s] = FACE_AXIS[f];
        pos_n[s] = FACE_POS[f];
      end
    end
  end

  // normal lanes: negated for a minus face, flipped once more when the start was inside
  always_comb begin
    logic flip;
    flip = in_s[RES_END] ^ !pos_s[RES_END];
    for (int k = 0; k < 3; k++) begin
      if (!hit_s[RES_END]) begin
        normal_next[k*LANE_W +: LANE_W] = '0;
      end else if (flip) begin
        normal_next[k*LANE_W +: LANE_W] = neg_sat16(ax_s[RES_END][nax_s[RES_END]][k]);
      end else begin
        normal_next[k*LANE_W +: LANE_W] = ax_s[RES_END][nax_s[RES_END]][k];
      end
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (en) begin
      c0 <= q_c;
      d0 <= q_d;
      e0 <= q_e;
      for (int f = 0; f < NUM_FACES; f++) begin
        r_s[0][f] <= RW'(q_num[f]);
      end
      den_s[0]  <= q_den;
      q_s[0]    <= '0;
      sat_s[0]  <= '0;
      skip_s[0] <= q_skip;
      ok_s[0]   <= '0;
      ax_s[0]   <= q_axis;
      in_s[0]   <= q_inside;
      lim_s[0]  <= q_tlim;
      hit_s[0]  <= 1'b0;
      nax_s[0]  <= AXIS_X;
      pos_s[0]  <= 1'b0;
      for (int s = 1; s <= DIV_END; s++) begin
        r_s[s]   <= r_n[s];
        den_s[s] <= den_s[s-1];
        q_s[s]   <= q_n[s];
      end
      for (int s = DIV_END + 1; s <= RES_END; s++) begin
        q_s[s] <= q_s[s-1];
      end
      for (int s = 1; s <= RES_END; s++) begin
        skip_s[s] <= skip_s[s-1];
        ax_s[s]   <= ax_s[s-1];
        in_s[s]   <= in_s[s-1];
        lim_s[s]  <= lim_n[s];
        hit_s[s]  <= hit_n[s];
        nax_s[s]  <= nax_n[s];
        pos_s[s]  <= pos_n[s];
      end
      for (int s = 2; s <= RES_END; s++) begin
        sat_s[s] <= sat_s[s-1];
      end
      for (int s = 3; s <= RES_END; s++) begin
        ok_s[s] <= ok_s[s-1];
      end
      // quotient overflow flag and containment result
      for (int f = 0; f < NUM_FACES; f++) begin
        sat_s[1][f] <= r_s[0][f] >= (RW'(den_s[0][f]) << 2);
      end
      ok_s[2] <= ok_n;
      for (int f = 0; f < NUM_FACES; f++) begin
        for (int k = 0; k < 3; k++) begin
          pa1[f][k] <= $signed({c0[k], 1'b0}) * $signed({1'b0, den_s[0][f]});
          pb1[f][k] <= $signed({1'b0, r_s[0][f][CW:0]}) * $signed({d0[k], 1'b0});
          pe1[f][k] <= $signed(e0[k]) * $signed({1'b0, den_s[0][f]});
        end
      end
      hit_o    <= hit_s[RES_END];
      normal_o <= normal_next;
      t_out_o  <= lim_s[RES_END];
    end
  end

  a_miss_zero_normal: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit_o |-> normal_o == '0)
    else $error("normal set without a hit");

  a_hit_lowers_limit: assert property (@(posedge clk) disable iff (rst)
    v[RES_END] && hit_s[RES_END] |-> lim_s[RES_END] < T_SAT)
    else $error("hit left the limit at its ceiling");

endmodule

// ===== rtl/swept_sphere_box_hit_top.sv =====
// ----------------------------------------------------------------------------
// swept_sphere_box_hit_top
// Swept sphere against oriented box test, one query per word.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one query word; m_axis returns one result word for each.
//   Results leave in the order the queries came in.
//   cfg_wen / cfg_wdata write the time margin; write only while idle.
// Pipeline: 5 front stages, one queue slot and 24 back stages (the input
//   register, 16 divider steps with the containment test alongside, 6 face
//   resolution steps and the output register).
// Throughput: one word per cycle while the back stages do not hold; set by the
//   per-bit divider pipeline, which takes a new quotient every cycle it moves.
// Reset: clears the valid flags, the queue and its credit count and loads
//   the margin with 164 (about 0.01 in Q0.14).
// Stall: when m_axis_tready is low while a result waits, the back stages hold;
//   the front keeps running into the queue and s_axis_tready drops once the
//   queue and the words in flight fill all QUEUE_DEPTH slots.
// ----------------------------------------------------------------------------
module swept_sphere_box_hit_top import ssbh_pkg::*; #(
  parameter int COORD_WIDTH = 16,
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst,
  // rel_pos[47:0], motion[95:48], radius[110:96], axis_x[158:111],
  // axis_y[206:159], axis_z[254:207], box_size[302:255], t_limit[318:303]
  input  logic [IN_W-1:0]     s_axis_tdata,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // hit[0], hit_normal[48:1], t_out[64:49]
  output logic [OUT_W-1:0]    m_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic                cfg_wen,
  input  logic [MARGIN_W-1:0] cfg_wdata
);

  localparam int CW    = COORD_WIDTH;
  localparam int QW    = NUM_FACES * (2 * (CW + 1) + 1) + 9 * CW + 144 + T_W + 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [MARGIN_W-1:0] time_margin;
  logic [CNT_W-1:0]    used;
  logic                accept, pop, f_valid, q_valid;
  logic [QW-1:0]       f_word, q_word;

  logic [NUM_FACES-1:0][CW:0]   f_num, f_den, b_num, b_den;
  logic [NUM_FACES-1:0]         f_skip, b_skip;
  logic [2:0][CW-1:0]           f_c, f_d, f_e, b_c, b_d, b_e;
  logic [2:0][2:0][LANE_W-1:0]  f_axis, b_axis;
  logic [T_W-1:0]               f_tlim, b_tlim, t_out;
  logic                         f_inside, b_inside, hit;
  logic [47:0]                  normal;

  // margin register
  always_ff @(posedge clk) begin
    if (rst) begin
      time_margin <= MARGIN_RESET;
    end else if (cfg_wen) begin
      time_margin <= cfg_wdata;
    end
  end

  // credits: words in the front plus words in the queue
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = used < CNT_W'(QUEUE_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      used <= used + CNT_W'(accept) - CNT_W'(pop);
    end
  end

  ssbh_front #(.CW(CW)) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .word     (s_axis_tdata),
    .f_valid  (f_valid),
    .f_num    (f_num),
    .f_den    (f_den),
    .f_skip   (f_skip),
    .f_c      (f_c),
    .f_d      (f_d),
    .f_e      (f_e),
    .f_axis   (f_axis),
    .f_tlim   (f_tlim),
    .f_inside (f_inside)
  );

  // queue word packing
  assign f_word = {f_inside, f_tlim, f_axis, f_e, f_d, f_c, f_skip, f_den, f_num};
  assign {b_inside, b_tlim, b_axis, b_e, b_d, b_c, b_skip, b_den, b_num} = q_word;

  ssbh_queue #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (f_valid),
    .wdata   (f_word),
    .pop     (pop),
    .q_valid (q_valid),
    .rdata   (q_word)
  );

  ssbh_back #(.CW(CW)) u_back (
    .clk         (clk),
    .rst         (rst),
    .time_margin (time_margin),
    .q_valid     (q_valid),
    .q_pop       (pop),
    .q_num       (b_num),
    .q_den       (b_den),
    .q_skip      (b_skip),
    .q_c         (b_c),
    .q_d         (b_d),
    .q_e         (b_e),
    .q_axis      (b_axis),
    .q_tlim      (b_tlim),
    .q_inside    (b_inside),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .hit_o       (hit),
    .normal_o    (normal),
    .t_out_o     (t_out)
  );

  assign m_axis_tdata = {7'b0, t_out, normal, hit};

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CNT_W'(QUEUE_DEPTH))
    else $error("credit count above queue depth");

endmodule
